/* rtl/mlpmt_pkg.sv */
// shared constants and controller/datapath interface types for the mtrr memory type block
package mlpmt_pkg;

	localparam int MAX_RANGES = 16;
	localparam int FRAME_BITS = 40;
	localparam int PAGE_BITS  = 31;
	localparam int TYPE_BITS  = 3;
	localparam int CMD_BITS   = 2;
	localparam int PAGE_SHIFT = 9;

	localparam int COUNT_W  = $clog2(MAX_RANGES + 1);
	localparam int IDX_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int QRY_BITS = PAGE_BITS + PAGE_SHIFT;
	localparam int CMP_BITS = (FRAME_BITS > QRY_BITS) ? FRAME_BITS : QRY_BITS;

	localparam logic [FRAME_BITS-1:0] FRAME_MASK = '1;
	localparam logic [COUNT_W-1:0]    COUNT_MAX  = COUNT_W'(MAX_RANGES);
	localparam logic [PAGE_SHIFT-1:0] PAGE_LOW   = '1;

	localparam logic [TYPE_BITS-1:0] TYPE_UC = 3'd0;
	localparam logic [TYPE_BITS-1:0] TYPE_WB = 3'd6;

	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic load;
		logic clear;
		logic add_off;
		logic add_write;
		logic scan;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/mtrr_large_page_memory_type.sv */
// top level: mtrr variable-range memory type resolution for 2 mb pages
// clear and add give no result transaction
// query: n stored ranges read one per cycle, then the result is registered
// frame zero or an uncacheable hit ends the walk early; in_stall drops in the same cycle as out_valid rises
// one transaction in flight at a time
// reset empties the table (count zero); table entries are not cleared
module mtrr_large_page_memory_type (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mlpmt_pkg::CMD_BITS-1:0]  cmd,
	input  logic [39:0]                     range_base_frame,
	input  logic [39:0]                     range_mask_frame,
	input  logic [mlpmt_pkg::TYPE_BITS-1:0] range_type,
	input  logic                            range_valid,
	input  logic [mlpmt_pkg::PAGE_BITS-1:0] page_frame,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mlpmt_pkg::TYPE_BITS-1:0] memory_type
);

	mlpmt_pkg::dp_cmd_t  ctl;
	mlpmt_pkg::dp_stat_t stat;

	mlpmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	mlpmt_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.range_base_frame (range_base_frame),
		.range_mask_frame (range_mask_frame),
		.range_type       (range_type),
		.range_valid      (range_valid),
		.page_frame       (page_frame),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.memory_type      (memory_type)
	);

endmodule

/* rtl/mlpmt_ctrl.sv */
// controller state machine: sequences clear, add and query transactions
module mlpmt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mlpmt_pkg::CMD_BITS-1:0] cmd,
	input  mlpmt_pkg::dp_stat_t           stat,
	output mlpmt_pkg::dp_cmd_t            ctl
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ADD1   = 5'b00010,
		ST_ADD2   = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		ctl.load      = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (cmd == mlpmt_pkg::CMD_CLEAR) begin
						ctl.clear = 1'b1;
					end else if (cmd == mlpmt_pkg::CMD_ADD) begin
						state_d = ST_ADD1;
					end else if (cmd == mlpmt_pkg::CMD_QUERY) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ADD1: begin
				ctl.add_off = 1'b1;
				state_d     = ST_ADD2;
			end
			ST_ADD2: begin
				ctl.add_write = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/mlpmt_datapath.sv */
// datapath: range table, end frame computation, range walk and output register
module mlpmt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlpmt_pkg::dp_cmd_t              ctl,
	output mlpmt_pkg::dp_stat_t             stat,
	input  logic [39:0]                     range_base_frame,
	input  logic [39:0]                     range_mask_frame,
	input  logic [mlpmt_pkg::TYPE_BITS-1:0] range_type,
	input  logic                            range_valid,
	input  logic [mlpmt_pkg::PAGE_BITS-1:0] page_frame,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mlpmt_pkg::TYPE_BITS-1:0] memory_type
);

	localparam int FB = mlpmt_pkg::FRAME_BITS;
	localparam int CB = mlpmt_pkg::CMP_BITS;
	localparam int TB = mlpmt_pkg::TYPE_BITS;

	logic [FB-1:0] start_mem [mlpmt_pkg::MAX_RANGES];
	logic [FB-1:0] end_mem   [mlpmt_pkg::MAX_RANGES];
	logic [TB-1:0] kind_mem  [mlpmt_pkg::MAX_RANGES];

	logic [mlpmt_pkg::COUNT_W-1:0] count_q;
	logic [mlpmt_pkg::COUNT_W-1:0] idx_q;

	logic [FB-1:0] base_q, mask_q, off_q;
	logic [TB-1:0] type_q;
	logic          valid_q;

	logic [CB-1:0] first_q, last_q;
	logic          zero_q, uc_q;
	logic [TB-1:0] kind_q;

	logic [FB-1:0] rd_start_s1, rd_end_s1;
	logic [TB-1:0] rd_kind_s1;
	logic          rd_vld_s1;

	logic [TB-1:0] out_type_q;
	logic          out_valid_q;

	logic [FB-1:0] mask_dec;
	logic [FB:0]   end_sum;
	logic [FB-1:0] end_frame;
	logic          add_ok;
	logic          issue;
	logic          overlap;
	logic [63:0]   base_in, mask_in;

	assign base_in = 64'(range_base_frame);
	assign mask_in = 64'(range_mask_frame);

	// mask minus one: ones below the lowest set mask bit, that bit cleared
	assign mask_dec  = mask_q - FB'(1);
	assign end_sum   = {1'b0, base_q} + {1'b0, off_q};
	assign end_frame = end_sum[FB] ? mlpmt_pkg::FRAME_MASK : end_sum[FB-1:0];
	assign add_ok    = valid_q && (type_q != mlpmt_pkg::TYPE_WB) && (mask_q != '0)
		&& (count_q < mlpmt_pkg::COUNT_MAX);

	assign issue   = ctl.scan && !uc_q && !zero_q && (idx_q != count_q);
	assign overlap = (first_q <= CB'(rd_end_s1)) && (last_q >= CB'(rd_start_s1));

	assign stat.scan_done = zero_q || uc_q || ((idx_q == count_q) && !rd_vld_s1);
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign memory_type = out_type_q;

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q  <= base_in[FB-1:0];
			mask_q  <= mask_in[FB-1:0];
			type_q  <= range_type;
			valid_q <= range_valid;
			first_q <= CB'({page_frame, {mlpmt_pkg::PAGE_SHIFT{1'b0}}});
			last_q  <= CB'({page_frame, mlpmt_pkg::PAGE_LOW});
			zero_q  <= (page_frame == '0);
		end
		if (ctl.add_off) begin
			off_q <= (mask_q ^ mask_dec) >> 1;
		end
	end

	// range table
	always_ff @(posedge clk) begin
		if (ctl.add_write && add_ok) begin
			start_mem[count_q[mlpmt_pkg::IDX_W-1:0]] <= base_q;
			end_mem[count_q[mlpmt_pkg::IDX_W-1:0]]   <= end_frame;
			kind_mem[count_q[mlpmt_pkg::IDX_W-1:0]]  <= type_q;
		end
		if (issue) begin
			rd_start_s1 <= start_mem[idx_q[mlpmt_pkg::IDX_W-1:0]];
			rd_end_s1   <= end_mem[idx_q[mlpmt_pkg::IDX_W-1:0]];
			rd_kind_s1  <= kind_mem[idx_q[mlpmt_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			uc_q      <= 1'b0;
			kind_q    <= mlpmt_pkg::TYPE_WB;
		end else begin
			if (ctl.clear) begin
				count_q <= '0;
			end else if (ctl.add_write && add_ok) begin
				count_q <= count_q + mlpmt_pkg::COUNT_W'(1);
			end
			if (ctl.load) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
				uc_q      <= 1'b0;
				kind_q    <= mlpmt_pkg::TYPE_WB;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + mlpmt_pkg::COUNT_W'(1);
				end
				if (rd_vld_s1 && !uc_q && overlap) begin
					kind_q <= rd_kind_s1;
					if (rd_kind_s1 == mlpmt_pkg::TYPE_UC) begin
						uc_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_type_q <= zero_q ? mlpmt_pkg::TYPE_UC : kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* sim/mtrr_large_page_memory_type_tb.sv */
// testbench for mtrr_large_page_memory_type: directed and random range tables with query checks
module mtrr_large_page_memory_type_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mlpmt_pkg::CMD_BITS-1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [mlpmt_pkg::TYPE_BITS-1:0] TYPE_WC      = 3'd1;
	localparam logic [mlpmt_pkg::TYPE_BITS-1:0] TYPE_WT      = 3'd4;
	localparam logic [mlpmt_pkg::TYPE_BITS-1:0] TYPE_WP      = 3'd5;
	localparam int                              ITEM_TARGET  = 1550;
	localparam int                              LIMIT_CYCLES = 1000000;
	localparam int                              MAX_PAUSE    = 16;

	typedef struct {
		logic [mlpmt_pkg::CMD_BITS-1:0]   op;
		logic [mlpmt_pkg::FRAME_BITS-1:0] base;
		logic [mlpmt_pkg::FRAME_BITS-1:0] mask;
		logic [mlpmt_pkg::TYPE_BITS-1:0]  kind;
		logic                             enable;
		logic [mlpmt_pkg::PAGE_BITS-1:0]  page;
	} mtrr_item_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [mlpmt_pkg::CMD_BITS-1:0]  cmd;
	logic [39:0]                     range_base_frame;
	logic [39:0]                     range_mask_frame;
	logic [mlpmt_pkg::TYPE_BITS-1:0] range_type;
	logic                            range_valid;
	logic [mlpmt_pkg::PAGE_BITS-1:0] page_frame;
	logic                            out_valid;
	logic                            out_stall;
	logic [mlpmt_pkg::TYPE_BITS-1:0] memory_type;

	// predicted range table
	logic [mlpmt_pkg::FRAME_BITS-1:0] tbl_start [mlpmt_pkg::MAX_RANGES];
	logic [mlpmt_pkg::FRAME_BITS-1:0] tbl_end   [mlpmt_pkg::MAX_RANGES];
	logic [mlpmt_pkg::TYPE_BITS-1:0]  tbl_kind  [mlpmt_pkg::MAX_RANGES];
	int                               tbl_count = 0;

	logic [mlpmt_pkg::TYPE_BITS-1:0]  expected_types [$];
	int                               errors      = 0;
	int                               items_sent  = 0;
	int                               cycle_count = 0;
	int                               stall_left  = 0;
	int                               hold_cycles = 0;
	bit                               no_idle     = 1'b0;

	mtrr_large_page_memory_type uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.range_base_frame (range_base_frame),
		.range_mask_frame (range_mask_frame),
		.range_type       (range_type),
		.range_valid      (range_valid),
		.page_frame       (page_frame),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.memory_type      (memory_type)
	);

	always #5 clk = ~clk;

	function automatic int pause_len();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_PAUSE);
	endfunction

	function automatic logic [mlpmt_pkg::FRAME_BITS-1:0] rand_frame();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[mlpmt_pkg::FRAME_BITS-1:0];
	endfunction

	function automatic void store_range(mtrr_item_t it);
		int                             k;
		logic [mlpmt_pkg::FRAME_BITS:0] stop;
		if (!it.enable || it.kind == mlpmt_pkg::TYPE_WB || it.mask == '0
			|| tbl_count >= mlpmt_pkg::MAX_RANGES)
			return;
		k = 0;
		while (!it.mask[k])
			k++;
		stop = {1'b0, it.base} + ((mlpmt_pkg::FRAME_BITS+1)'(1) << k) - 1'b1;
		tbl_start[tbl_count] = it.base;
		tbl_end[tbl_count]   = stop[mlpmt_pkg::FRAME_BITS] ? mlpmt_pkg::FRAME_MASK
			: stop[mlpmt_pkg::FRAME_BITS-1:0];
		tbl_kind[tbl_count]  = it.kind;
		tbl_count++;
	endfunction

	function automatic logic [mlpmt_pkg::TYPE_BITS-1:0] resolve_type(
			logic [mlpmt_pkg::PAGE_BITS-1:0] pf);
		logic [mlpmt_pkg::FRAME_BITS-1:0] first;
		logic [mlpmt_pkg::FRAME_BITS-1:0] last;
		logic [mlpmt_pkg::TYPE_BITS-1:0]  kind;
		if (pf == '0)
			return mlpmt_pkg::TYPE_UC;
		first = {pf, {mlpmt_pkg::PAGE_SHIFT{1'b0}}};
		last  = {pf, mlpmt_pkg::PAGE_LOW};
		kind  = mlpmt_pkg::TYPE_WB;
		for (int i = 0; i < tbl_count; i++) begin
			if (first <= tbl_end[i] && last >= tbl_start[i]) begin
				kind = tbl_kind[i];
				if (kind == mlpmt_pkg::TYPE_UC)
					break;
			end
		end
		return kind;
	endfunction

	task automatic send_item(mtrr_item_t it);
		int gap;
		gap = pause_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid         <= 1'b1;
		cmd              <= it.op;
		range_base_frame <= it.base;
		range_mask_frame <= it.mask;
		range_type       <= it.kind;
		range_valid      <= it.enable;
		page_frame       <= it.page;
		do @(posedge clk); while (in_stall);
		case (it.op)
			mlpmt_pkg::CMD_CLEAR: tbl_count = 0;
			mlpmt_pkg::CMD_ADD:   store_range(it);
			mlpmt_pkg::CMD_QUERY: expected_types.push_back(resolve_type(it.page));
			default: ;
		endcase
		if (it.op != CMD_UNUSED)
			items_sent++;
	endtask

	function automatic mtrr_item_t random_item(logic [mlpmt_pkg::CMD_BITS-1:0] op);
		mtrr_item_t it;
		it.op     = op;
		it.base   = rand_frame();
		it.mask   = rand_frame();
		it.kind   = mlpmt_pkg::TYPE_BITS'($urandom_range(0, 7));
		it.enable = 1'($urandom_range(0, 1));
		it.page   = mlpmt_pkg::PAGE_BITS'($urandom);
		return it;
	endfunction

	task automatic send_cmd(logic [mlpmt_pkg::CMD_BITS-1:0] op);
		send_item(random_item(op));
	endtask

	task automatic send_add(logic [mlpmt_pkg::FRAME_BITS-1:0] base,
			logic [mlpmt_pkg::FRAME_BITS-1:0] mask,
			logic [mlpmt_pkg::TYPE_BITS-1:0] kind, logic enable);
		mtrr_item_t it;
		it        = random_item(mlpmt_pkg::CMD_ADD);
		it.base   = base;
		it.mask   = mask;
		it.kind   = kind;
		it.enable = enable;
		send_item(it);
	endtask

	task automatic send_query(logic [mlpmt_pkg::PAGE_BITS-1:0] pf);
		mtrr_item_t it;
		it      = random_item(mlpmt_pkg::CMD_QUERY);
		it.page = pf;
		send_item(it);
	endtask

	function automatic logic [mlpmt_pkg::FRAME_BITS-1:0] page_base(
			logic [mlpmt_pkg::PAGE_BITS-1:0] pf);
		return {pf, {mlpmt_pkg::PAGE_SHIFT{1'b0}}};
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_types.size() == 0) begin
				$display("%0t: unexpected result transaction, memory_type %0d",
					$time, memory_type);
				errors++;
			end else begin
				if (memory_type !== expected_types[0]) begin
					$display("%0t: memory_type expected %0d, actual %0d",
						$time, expected_types[0], memory_type);
					errors++;
				end
				void'(expected_types.pop_front());
			end
			stall_left = pause_len();
		end
	end

	// receiver stall, including long hold-offs
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	task automatic test_frame_zero;
		send_cmd(mlpmt_pkg::CMD_CLEAR);
		send_query('0);
		send_add('0, 40'd1 << mlpmt_pkg::PAGE_SHIFT, TYPE_WT, 1'b1);
		send_query('0);
		send_query('1);
	endtask

	task automatic test_dropped_adds;
		send_cmd(mlpmt_pkg::CMD_CLEAR);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(3)), 40'd1 << mlpmt_pkg::PAGE_SHIFT,
			mlpmt_pkg::TYPE_UC, 1'b0);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(3)), 40'd1 << mlpmt_pkg::PAGE_SHIFT,
			mlpmt_pkg::TYPE_WB, 1'b1);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(3)), '0, mlpmt_pkg::TYPE_UC, 1'b1);
		send_query(mlpmt_pkg::PAGE_BITS'(3));
		send_cmd(CMD_UNUSED);
		send_query(mlpmt_pkg::PAGE_BITS'(3));
	endtask

	task automatic test_saturation;
		send_add('1, 40'd1 << (mlpmt_pkg::FRAME_BITS - 1), TYPE_WC, 1'b1);
		send_add('1, '1, TYPE_WT, 1'b1);
		send_query('1);
		send_query(mlpmt_pkg::PAGE_BITS'(1) << (mlpmt_pkg::PAGE_BITS - 1));
	endtask

	task automatic test_overlap_order;
		send_cmd(mlpmt_pkg::CMD_CLEAR);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(5)), 40'd1 << mlpmt_pkg::PAGE_SHIFT,
			TYPE_WT, 1'b1);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(5)) + 40'd100, '1, TYPE_WP, 1'b1);
		send_query(mlpmt_pkg::PAGE_BITS'(5));
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(5)), 40'd1 << (mlpmt_pkg::PAGE_SHIFT + 1),
			mlpmt_pkg::TYPE_UC, 1'b1);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(5)), 40'd1 << mlpmt_pkg::PAGE_SHIFT,
			TYPE_WC, 1'b1);
		send_query(mlpmt_pkg::PAGE_BITS'(5));
		send_query(mlpmt_pkg::PAGE_BITS'(6));
		send_query(mlpmt_pkg::PAGE_BITS'(4));
	endtask

	task automatic test_backpressure;
		send_cmd(mlpmt_pkg::CMD_CLEAR);
		send_add(page_base(mlpmt_pkg::PAGE_BITS'(9)), 40'd1 << mlpmt_pkg::PAGE_SHIFT,
			TYPE_WP, 1'b1);
		no_idle     = 1'b1;
		hold_cycles = 400;
		for (int i = 0; i < 24; i++)
			send_query(mlpmt_pkg::PAGE_BITS'(8 + i % 3));
		no_idle = 1'b0;
	endtask

	function automatic logic [mlpmt_pkg::PAGE_BITS-1:0] pick_page(bit clustered);
		int                               r;
		int                               i;
		logic [mlpmt_pkg::FRAME_BITS-1:0] f;
		logic [mlpmt_pkg::PAGE_BITS-1:0]  p;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r < 11 && tbl_count > 0) begin
			i = $urandom_range(0, tbl_count - 1);
			f = $urandom_range(0, 1) ? tbl_start[i] : tbl_end[i];
			p = f[mlpmt_pkg::FRAME_BITS-1:mlpmt_pkg::PAGE_SHIFT];
			case ($urandom_range(0, 2))
				0: if (p != '0) p = p - 1'b1;
				2: if (p != '1) p = p + 1'b1;
				default: ;
			endcase
			return p;
		end
		if (clustered && r < 17)
			return mlpmt_pkg::PAGE_BITS'($urandom_range(0, 70));
		return mlpmt_pkg::PAGE_BITS'($urandom);
	endfunction

	task automatic test_random_sequences;
		int                               next_switch;
		int                               n_add;
		int                               n_query;
		int                               k;
		bit                               clustered;
		logic [mlpmt_pkg::FRAME_BITS-1:0] base;
		logic [mlpmt_pkg::FRAME_BITS-1:0] mask;
		next_switch = items_sent + 150;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= next_switch) begin
				no_idle     = ($urandom_range(0, 3) == 0);
				next_switch = items_sent + 150;
			end
			if ($urandom_range(0, 5) != 0)
				send_cmd(mlpmt_pkg::CMD_CLEAR);
			clustered = 1'($urandom_range(0, 1));
			n_add     = $urandom_range(0, 20);
			for (int j = 0; j < n_add; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_cmd(CMD_UNUSED);
				end else begin
					if (clustered) begin
						base = (mlpmt_pkg::FRAME_BITS'($urandom_range(0, 63))
							<< mlpmt_pkg::PAGE_SHIFT)
							+ mlpmt_pkg::FRAME_BITS'($urandom_range(0, 1023));
						k = $urandom_range(0, 14);
					end else begin
						base = rand_frame();
						k = $urandom_range(0, mlpmt_pkg::FRAME_BITS - 1);
					end
					mask = (rand_frame() << k) | (mlpmt_pkg::FRAME_BITS'(1) << k);
					if ($urandom_range(0, 19) == 0)
						mask = '0;
					send_add(base, mask, mlpmt_pkg::TYPE_BITS'($urandom_range(0, 7)),
						$urandom_range(0, 9) != 0);
				end
			end
			n_query = $urandom_range(3, 10);
			for (int j = 0; j < n_query; j++)
				send_query(pick_page(clustered));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		cmd              = mlpmt_pkg::CMD_CLEAR;
		range_base_frame = '0;
		range_mask_frame = '0;
		range_type       = mlpmt_pkg::TYPE_UC;
		range_valid      = 1'b0;
		page_frame       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_frame_zero;
		test_dropped_adds;
		test_saturation;
		test_overlap_order;
		test_backpressure;
		test_random_sequences;

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_types.size() != 0)
			@(posedge clk);
		repeat (mlpmt_pkg::MAX_RANGES + 8) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
